/* hw/rtl/lss_pkg.sv */
// Package for the load/store/stack unit: transaction types, opcode and
// register codes, memory request type and register file helper functions.
// Depends on nothing; used by every file of the unit.
package lss_pkg;

    // Opcodes of the load group.
    localparam logic [3:0] OP_HL_SP_OFF = 4'd0;
    localparam logic [3:0] OP_R_R       = 4'd1;
    localparam logic [3:0] OP_R_IMM     = 4'd2;
    localparam logic [3:0] OP_R_MEM     = 4'd3;
    localparam logic [3:0] OP_MEM_R     = 4'd4;
    localparam logic [3:0] OP_MEM_IMM   = 4'd5;
    localparam logic [3:0] OP_RR_IMM    = 4'd6;
    localparam logic [3:0] OP_RR_MEM    = 4'd7;
    localparam logic [3:0] OP_MEM_RR    = 4'd8;
    localparam logic [3:0] OP_SP_HL     = 4'd9;
    localparam logic [3:0] OP_PUSH      = 4'd10;
    localparam logic [3:0] OP_POP       = 4'd11;

    // 8-bit register codes.
    localparam logic [2:0] R_A = 3'd0;
    localparam logic [2:0] R_F = 3'd1;
    localparam logic [2:0] R_B = 3'd2;
    localparam logic [2:0] R_C = 3'd3;
    localparam logic [2:0] R_D = 3'd4;
    localparam logic [2:0] R_E = 3'd5;
    localparam logic [2:0] R_H = 3'd6;
    localparam logic [2:0] R_L = 3'd7;

    // Register pair codes.
    localparam logic [2:0] P_AF = 3'd0;
    localparam logic [2:0] P_BC = 3'd1;
    localparam logic [2:0] P_DE = 3'd2;
    localparam logic [2:0] P_HL = 3'd3;
    localparam logic [2:0] P_SP = 3'd4;

    // Status codes.
    localparam logic ST_DONE = 1'b0;
    localparam logic ST_BAD  = 1'b1;

    // A popped F register keeps only its upper nibble.
    localparam logic [15:0] POP_AF_MASK = 16'hFFF0;

    typedef struct packed {
        logic [3:0]  op;
        logic [2:0]  src_reg;
        logic [2:0]  dst_reg;
        logic [2:0]  pair_sel;
        logic [15:0] addr;
        logic [15:0] imm;
    } item_t;

    typedef struct packed {
        logic [15:0] out_af;
        logic [15:0] out_bc;
        logic [15:0] out_de;
        logic [15:0] out_hl;
        logic [15:0] out_sp;
        logic        status;
    } result_t;

    typedef struct packed {
        logic [7:0]  a;
        logic [7:0]  f;
        logic [7:0]  b;
        logic [7:0]  c;
        logic [7:0]  d;
        logic [7:0]  e;
        logic [7:0]  h;
        logic [7:0]  l;
        logic [15:0] sp;
    } regfile_t;

    // One byte access to the data memory.
    typedef struct packed {
        logic        en;
        logic        we;
        logic [15:0] addr;
        logic [7:0]  wdata;
    } mem_req_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_STEP1,
        S_STEP2
    } state_t;

    function automatic logic [7:0] reg8_get(regfile_t rf, logic [2:0] sel);
        logic [7:0] v;
        case (sel)
            R_A:     v = rf.a;
            R_F:     v = rf.f;
            R_B:     v = rf.b;
            R_C:     v = rf.c;
            R_D:     v = rf.d;
            R_E:     v = rf.e;
            R_H:     v = rf.h;
            default: v = rf.l;
        endcase
        return v;
    endfunction

    function automatic regfile_t reg8_set(regfile_t rf, logic [2:0] sel, logic [7:0] v);
        regfile_t r;
        r = rf;
        case (sel)
            R_A:     r.a = v;
            R_F:     r.f = v;
            R_B:     r.b = v;
            R_C:     r.c = v;
            R_D:     r.d = v;
            R_E:     r.e = v;
            R_H:     r.h = v;
            default: r.l = v;
        endcase
        return r;
    endfunction

    function automatic logic [15:0] pair_get(regfile_t rf, logic [2:0] sel);
        logic [15:0] v;
        case (sel)
            P_AF:    v = {rf.a, rf.f};
            P_BC:    v = {rf.b, rf.c};
            P_DE:    v = {rf.d, rf.e};
            P_HL:    v = {rf.h, rf.l};
            default: v = rf.sp;
        endcase
        return v;
    endfunction

    function automatic regfile_t pair_set(regfile_t rf, logic [2:0] sel, logic [15:0] v);
        regfile_t r;
        r = rf;
        case (sel)
            P_AF:    {r.a, r.f} = v;
            P_BC:    {r.b, r.c} = v;
            P_DE:    {r.d, r.e} = v;
            P_HL:    {r.h, r.l} = v;
            default: r.sp = v;
        endcase
        return r;
    endfunction

    // True when the transaction names a register or opcode that is not allowed.
    function automatic logic item_bad(item_t it);
        logic bad;
        case (it.op)
            OP_HL_SP_OFF, OP_R_IMM, OP_MEM_IMM, OP_SP_HL: bad = 1'b0;
            OP_R_R:    bad = (it.src_reg == R_F) || (it.dst_reg == R_F);
            OP_R_MEM:  bad = (it.dst_reg == R_F);
            OP_MEM_R:  bad = (it.src_reg == R_F);
            OP_RR_IMM, OP_RR_MEM, OP_MEM_RR: bad = (it.pair_sel > P_SP);
            OP_PUSH, OP_POP: bad = (it.pair_sel > P_HL);
            default:   bad = 1'b1;
        endcase
        return bad;
    endfunction

endpackage

/* hw/rtl/lss_dmem.sv */
// Byte-wide single-port data memory with a registered read port.
// Depends on lss_pkg for the memory request type.
module lss_dmem
    import lss_pkg::*;
#(
    parameter int ADDR_BITS = 16
)
(
    input  logic       clk,
    input  mem_req_t   req,
    output logic [7:0] rdata
);

    logic [7:0] mem [2**ADDR_BITS];
    logic [7:0] rdata_reg;

    // One access per cycle: a write, or a read whose data appears next cycle.
    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            if (req.we)
            begin
                mem[req.addr[ADDR_BITS-1:0]] <= req.wdata;
            end
            else
            begin
                rdata_reg <= mem[req.addr[ADDR_BITS-1:0]];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/cpu_load_store_stack_unit.sv */
// Load/store/stack unit: one transaction in, one result out, at most one register update per item.
// Result: registered at the end of S_STEP1, or of S_STEP2 for 16-bit loads and pop, once the result slot is free.
// Transactions: a new one is taken only in S_IDLE, after the previous result is registered; the
// data memory has a single byte port, one byte access per cycle.
// Reset: A, F, B, C, D, E, H, L and SP clear to zero; memory contents are not initialized.
// Depends on lss_pkg and lss_dmem.
module cpu_load_store_stack_unit
    import lss_pkg::*;
#(
    parameter int ADDR_BITS = 16
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    state_t   state_reg, state_next;
    item_t    item_reg;
    regfile_t rf_reg, rf_next;
    logic [7:0] lo_reg;
    logic     result_valid_reg;
    result_t  result_reg;

    mem_req_t   mem_req;
    logic [7:0] mem_rdata;
    logic       slot_free;
    logic       finish;
    logic       capture_lo;
    logic       rd16;
    logic       bad;

    // First byte access, issued in the cycle the transaction is accepted.
    function automatic mem_req_t access_first(item_t it, regfile_t rf);
        mem_req_t    q;
        logic        b;
        logic [15:0] pv;
        q  = '0;
        b  = item_bad(it);
        pv = pair_get(rf, it.pair_sel);
        case (it.op)
            OP_R_MEM, OP_RR_MEM:
            begin
                q.en   = 1'b1;
                q.addr = it.addr;
            end
            OP_MEM_R:
            begin
                q.en    = !b;
                q.we    = 1'b1;
                q.addr  = it.addr;
                q.wdata = reg8_get(rf, it.src_reg);
            end
            OP_MEM_IMM:
            begin
                q.en    = 1'b1;
                q.we    = 1'b1;
                q.addr  = it.addr;
                q.wdata = it.imm[7:0];
            end
            OP_MEM_RR:
            begin
                q.en    = !b;
                q.we    = 1'b1;
                q.addr  = it.addr;
                q.wdata = pv[7:0];
            end
            OP_PUSH:
            begin
                q.en    = !b;
                q.we    = 1'b1;
                q.addr  = rf.sp - 16'd1;
                q.wdata = pv[15:8];
            end
            OP_POP:
            begin
                q.en   = 1'b1;
                q.addr = rf.sp;
            end
            default:
            begin
                q = '0;
            end
        endcase
        return q;
    endfunction

    // Second byte access of the 16-bit memory and stack operations.
    function automatic mem_req_t access_second(item_t it, regfile_t rf);
        mem_req_t    q;
        logic        b;
        logic [15:0] pv;
        q  = '0;
        b  = item_bad(it);
        pv = pair_get(rf, it.pair_sel);
        case (it.op)
            OP_RR_MEM:
            begin
                q.en   = 1'b1;
                q.addr = it.addr + 16'd1;
            end
            OP_MEM_RR:
            begin
                q.en    = !b;
                q.we    = 1'b1;
                q.addr  = it.addr + 16'd1;
                q.wdata = pv[15:8];
            end
            OP_PUSH:
            begin
                q.en    = !b;
                q.we    = 1'b1;
                q.addr  = rf.sp - 16'd2;
                q.wdata = pv[7:0];
            end
            OP_POP:
            begin
                q.en   = 1'b1;
                q.addr = rf.sp + 16'd1;
            end
            default:
            begin
                q = '0;
            end
        endcase
        return q;
    endfunction

    lss_dmem #(
        .ADDR_BITS (ADDR_BITS)
    ) u_dmem (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    assign slot_free = !result_valid_reg || !result_stall;
    assign rd16      = (item_reg.op == OP_RR_MEM) || (item_reg.op == OP_POP);
    assign bad       = item_bad(item_reg);

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = S_STEP1;
                end
            end
            S_STEP1:
            begin
                if (rd16)
                begin
                    state_next = S_STEP2;
                end
                else if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_STEP2:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sequencer outputs: handshake, memory port and completion strobes.
    always_comb
    begin
        item_stall = 1'b1;
        mem_req    = '0;
        finish     = 1'b0;
        capture_lo = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                item_stall = 1'b0;
                if (item_valid)
                begin
                    mem_req = access_first(item, rf_reg);
                end
            end
            S_STEP1:
            begin
                mem_req = access_second(item_reg, rf_reg);
                if (rd16)
                begin
                    capture_lo = 1'b1;
                end
                else
                begin
                    finish = slot_free;
                end
            end
            S_STEP2:
            begin
                finish = slot_free;
            end
            default:
            begin
                item_stall = 1'b1;
            end
        endcase
    end

    // Register file update for the transaction held in item_reg.
    always_comb
    begin
        logic [7:0]  ofs;
        logic [15:0] sum;
        logic [4:0]  half_sum;
        logic [8:0]  byte_sum;
        logic [15:0] ld16;
        ofs      = item_reg.imm[7:0];
        sum      = rf_reg.sp + {{8{ofs[7]}}, ofs};
        half_sum = {1'b0, rf_reg.sp[3:0]} + {1'b0, ofs[3:0]};
        byte_sum = {1'b0, rf_reg.sp[7:0]} + {1'b0, ofs};
        ld16     = {mem_rdata, lo_reg};
        rf_next  = rf_reg;
        case (item_reg.op)
            OP_HL_SP_OFF:
            begin
                rf_next.f = {2'b00, half_sum[4], byte_sum[8], rf_reg.f[3:0]};
                rf_next.h = sum[15:8];
                rf_next.l = sum[7:0];
            end
            OP_R_R:
            begin
                rf_next = reg8_set(rf_reg, item_reg.dst_reg,
                                   reg8_get(rf_reg, item_reg.src_reg));
            end
            OP_R_IMM:
            begin
                rf_next = reg8_set(rf_reg, item_reg.dst_reg, item_reg.imm[7:0]);
            end
            OP_R_MEM:
            begin
                rf_next = reg8_set(rf_reg, item_reg.dst_reg, mem_rdata);
            end
            OP_RR_IMM:
            begin
                rf_next = pair_set(rf_reg, item_reg.pair_sel, item_reg.imm);
            end
            OP_RR_MEM:
            begin
                rf_next = pair_set(rf_reg, item_reg.pair_sel, ld16);
            end
            OP_SP_HL:
            begin
                rf_next.sp = {rf_reg.h, rf_reg.l};
            end
            OP_PUSH:
            begin
                rf_next.sp = rf_reg.sp - 16'd2;
            end
            OP_POP:
            begin
                rf_next.sp = rf_reg.sp + 16'd2;
                if (item_reg.pair_sel == P_AF)
                begin
                    rf_next = pair_set(rf_next, P_AF, ld16 & POP_AF_MASK);
                end
                else
                begin
                    rf_next = pair_set(rf_next, item_reg.pair_sel, ld16);
                end
            end
            default:
            begin
                rf_next = rf_reg;
            end
        endcase
        if (bad)
        begin
            rf_next = rf_reg;
        end
    end

    // Control state and architectural registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            rf_reg           <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (finish)
            begin
                rf_reg           <= rf_next;
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: held transaction, low byte of a 16-bit load, result.
    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            item_reg <= item;
        end
        if (capture_lo)
        begin
            lo_reg <= mem_rdata;
        end
        if (finish)
        begin
            result_reg.out_af <= pair_get(rf_next, P_AF);
            result_reg.out_bc <= pair_get(rf_next, P_BC);
            result_reg.out_de <= pair_get(rf_next, P_DE);
            result_reg.out_hl <= pair_get(rf_next, P_HL);
            result_reg.out_sp <= rf_next.sp;
            result_reg.status <= bad ? ST_BAD : ST_DONE;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

/* hw/rtl/lss_checker.sv */
// Port-level checker for the load/store/stack unit, bound to the top level.
// Depends on lss_pkg for the transaction types.
module lss_checker
    import lss_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    item_valid,
    input logic    item_stall,
    input logic    result_valid,
    input logic    result_stall,
    input result_t result
);

    logic [79:0] last_regs_reg;
    logic [79:0] cur_regs;

    assign cur_regs = {result.out_af, result.out_bc, result.out_de,
                       result.out_hl, result.out_sp};

    // Register values shown by the most recent delivered result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_regs_reg <= '0;
        end
        else if (result_valid && !result_stall)
        begin
            last_regs_reg <= cur_regs;
        end
    end

    // The unit takes one transaction at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
        else $error("transaction accepted while previous one still in work");

    // A stalled result holds.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed");

    // A rejected transaction leaves every register as the previous result showed it.
    a_bad_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status == ST_BAD |-> cur_regs == last_regs_reg)
        else $error("invalid transaction changed registers");

    // A new result only follows a transaction in work.
    a_result_after_item: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(item_stall))
        else $error("result appeared without a transaction in work");

endmodule

bind cpu_load_store_stack_unit lss_checker u_lss_checker (.*);
